[hw/rtl/uttc_pkg.sv]
// Shared types, constants and the month-start table of the seconds-to-calendar converter.
// No dependencies; every other file of the block imports this package.
package uttc_pkg;

  // Seconds at 2100-01-01 00:00:00; this and everything above is out of range.
  localparam logic [31:0] LimitSec = 32'd4102444800;

  // Reciprocals for constant division, exact over the input ranges used here.
  // days = (sec >> 7) / 675, with sec >> 7 below 2^25
  localparam logic [25:0] DayRecip  = 26'd50903317;
  localparam int unsigned DayShift  = 35;
  // group = (days - 730) / 1461, with the dividend below 2^16
  localparam logic [16:0] GrpRecip  = 17'd91868;
  localparam int unsigned GrpShift  = 27;
  // (days + 4) / 7, with the dividend below 2^17
  localparam logic [17:0] WeekRecip = 18'd149797;
  localparam int unsigned WeekShift = 20;
  // rem / 3600 and rem / 60, with rem below 2^17
  localparam logic [17:0] HourRecip = 18'd149131;
  localparam int unsigned HourShift = 29;
  localparam logic [17:0] MinRecip  = 18'd139811;
  localparam int unsigned MinShift  = 23;

  localparam logic [9:0]  DayBlocks     = 10'd675;   // 86400 / 128
  localparam logic [15:0] DaysBefore72  = 16'd730;
  localparam logic [10:0] DaysPerGroup  = 11'd1461;
  localparam logic [15:0] DaysPerYear   = 16'd365;
  localparam logic [11:0] Year1970      = 12'd1970;
  localparam logic [11:0] Year1972      = 12'd1972;

  // Stage payloads
  typedef struct packed {
    logic        oor;
    logic [15:0] days;
    logic [31:0] sec;
  } stg_b_t;

  typedef struct packed {
    logic        oor;
    logic        early;     // day falls in 1970 or 1971
    logic [15:0] days;
    logic [15:0] dgrp;      // days since 1972-01-01
    logic [5:0]  grp;       // four-year group index
    logic [14:0] wq;        // (days + 4) / 7
    logic [16:0] rem;       // seconds in the day
  } stg_c_t;

  typedef struct packed {
    logic        oor;
    logic        leap;
    logic [11:0] year;
    logic [8:0]  doy;       // day of year, from 0
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [10:0] rem_min;   // minutes in the day
    logic [16:0] rem;
  } stg_d_t;

  typedef struct packed {
    logic        oor;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } res_t;

  // Days before the first of a month (index 0 = January); index 12 is the year end.
  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] val;
    unique case (idx)
      4'd0:    val = 9'd0;
      4'd1:    val = 9'd31;
      4'd2:    val = 9'd59;
      4'd3:    val = 9'd90;
      4'd4:    val = 9'd120;
      4'd5:    val = 9'd151;
      4'd6:    val = 9'd181;
      4'd7:    val = 9'd212;
      4'd8:    val = 9'd243;
      4'd9:    val = 9'd273;
      4'd10:   val = 9'd304;
      4'd11:   val = 9'd334;
      4'd12:   val = 9'd365;
      default: val = 9'd0;
    endcase
    return val;
  endfunction

endpackage

[hw/rtl/uttc_day_split.sv]
// First logic stage: range check and whole days from the second count.
// Depends on uttc_pkg.
module uttc_day_split import uttc_pkg::*; (
  input  logic [31:0] sec_i,
  output stg_b_t      stg_o
);

  logic [50:0] prod;

  // 86400 = 128 * 675: drop the power of two, then multiply by the reciprocal of 675
  assign prod = 51'(sec_i[31:7]) * 51'(DayRecip);

  assign stg_o.oor  = (sec_i >= LimitSec);
  assign stg_o.days = prod[50:DayShift];
  assign stg_o.sec  = sec_i;

endmodule

[hw/rtl/uttc_group_split.sv]
// Second logic stage: seconds in the day, four-year group and weekday quotient.
// Depends on uttc_pkg.
module uttc_group_split import uttc_pkg::*; (
  input  stg_b_t stg_i,
  output stg_c_t stg_o
);

  logic [24:0] q7;
  logic [25:0] dmul;
  logic [9:0]  r675;
  logic [15:0] dgrp;
  logic [32:0] gprod;
  logic [16:0] wx;
  logic [34:0] wprod;

  assign q7   = stg_i.sec[31:7];
  assign dmul = 26'(stg_i.days) * 26'(DayBlocks);
  // true difference is below 675, so the low bits carry it
  assign r675 = q7[9:0] - dmul[9:0];

  assign dgrp  = stg_i.days - DaysBefore72;
  assign gprod = 33'(dgrp) * 33'(GrpRecip);

  assign wx    = 17'(stg_i.days) + 17'd4;
  assign wprod = 35'(wx) * 35'(WeekRecip);

  assign stg_o.oor   = stg_i.oor;
  assign stg_o.early = (stg_i.days < DaysBefore72);
  assign stg_o.days  = stg_i.days;
  assign stg_o.dgrp  = dgrp;
  assign stg_o.grp   = gprod[32:GrpShift];
  assign stg_o.wq    = wprod[34:WeekShift];
  assign stg_o.rem   = {r675, stg_i.sec[6:0]};

endmodule

[hw/rtl/uttc_year_split.sv]
// Third logic stage: year, day of year, leap flag, weekday, hour and minutes in the day.
// Depends on uttc_pkg.
module uttc_year_split import uttc_pkg::*; (
  input  stg_c_t stg_i,
  output stg_d_t stg_o
);

  logic [16:0] gmul;
  logic [10:0] r;
  logic [1:0]  yoff;
  logic [8:0]  gdoy;
  logic [11:0] gyear;
  logic [2:0]  wx;
  logic [17:0] w7;
  logic [34:0] hprod;
  logic [34:0] mprod;
  logic        leap;
  logic [11:0] year;
  logic [8:0]  doy;

  assign gmul = 17'(stg_i.grp) * 17'(DaysPerGroup);
  assign r    = stg_i.dgrp[10:0] - gmul[10:0];

  // leap year opens each group
  always_comb begin
    if (r < 11'd366) begin
      yoff = 2'd0;
      gdoy = r[8:0];
    end else if (r < 11'd731) begin
      yoff = 2'd1;
      gdoy = 9'(r - 11'd366);
    end else if (r < 11'd1096) begin
      yoff = 2'd2;
      gdoy = 9'(r - 11'd731);
    end else begin
      yoff = 2'd3;
      gdoy = 9'(r - 11'd1096);
    end
  end

  assign gyear = Year1972 + {4'd0, stg_i.grp, 2'b00} + 12'(yoff);

  always_comb begin
    if (stg_i.early) begin
      leap = 1'b0;
      if (stg_i.days < DaysPerYear) begin
        year = Year1970;
        doy  = stg_i.days[8:0];
      end else begin
        year = Year1970 + 12'd1;
        doy  = 9'(stg_i.days - DaysPerYear);
      end
    end else begin
      leap = (yoff == 2'd0);
      year = gyear;
      doy  = gdoy;
    end
  end

  // 1970-01-01 was a Thursday
  assign wx = stg_i.days[2:0] + 3'd4;
  assign w7 = 18'(stg_i.wq) * 18'd7;

  assign hprod = 35'(stg_i.rem) * 35'(HourRecip);
  assign mprod = 35'(stg_i.rem) * 35'(MinRecip);

  assign stg_o.oor     = stg_i.oor;
  assign stg_o.leap    = leap;
  assign stg_o.year    = year;
  assign stg_o.doy     = doy;
  assign stg_o.weekday = wx - w7[2:0];
  assign stg_o.hour    = hprod[33:HourShift];
  assign stg_o.rem_min = mprod[33:MinShift];
  assign stg_o.rem     = stg_i.rem;

endmodule

[hw/rtl/uttc_month_time.sv]
// Last logic stage: month and day from the day of year, minute and second, range masking.
// Depends on uttc_pkg.
module uttc_month_time import uttc_pkg::*; (
  input  stg_d_t stg_i,
  output res_t   res_o
);

  logic [3:0]  month;
  logic [8:0]  start;
  logic [8:0]  dday;
  logic [10:0] h60;
  logic [10:0] mdiff;
  logic [16:0] m60;
  logic [16:0] sdiff;

  // first month whose end lies past the day of year
  always_comb begin
    month = 4'd12;
    for (int i = 12; i >= 1; i--) begin
      if (stg_i.doy < month_start(4'(i)) + 9'((stg_i.leap && i >= 2) ? 1 : 0)) begin
        month = 4'(i);
      end
    end
  end

  assign start = month_start(month - 4'd1) + 9'((stg_i.leap && month >= 4'd3) ? 1 : 0);
  assign dday  = stg_i.doy - start + 9'd1;

  assign h60   = 11'(stg_i.hour) * 11'd60;
  assign mdiff = stg_i.rem_min - h60;
  assign m60   = 17'(stg_i.rem_min) * 17'd60;
  assign sdiff = stg_i.rem - m60;

  always_comb begin
    if (stg_i.oor) begin
      res_o = '0;
      res_o.oor = 1'b1;
    end else begin
      res_o.oor     = 1'b0;
      res_o.year    = stg_i.year;
      res_o.month   = month;
      res_o.day     = dday[4:0];
      res_o.weekday = stg_i.weekday;
      res_o.hour    = stg_i.hour;
      res_o.minute  = mdiff[5:0];
      res_o.second  = sdiff[5:0];
    end
  end

endmodule

[hw/rtl/unix_time_to_calendar.sv]
// Top level of the seconds-to-calendar converter: stream ports and pipeline registers.
// Depends on uttc_pkg, uttc_day_split, uttc_group_split, uttc_year_split, uttc_month_time.
//
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 UTC into year, month,
// day of month, weekday (0 = Sunday) and time of day. Each request is independent.
// The converter is a five-register pipeline (input register, three inner ranks, result
// register) with constant-reciprocal multipliers between ranks; it takes one request
// every cycle unless all ranks hold data and m_axis_tready is low. Each rank advances
// on its own when the rank after it is empty or moving, so a result waiting on
// m_axis_tready does not stop new requests until all five ranks hold data. Requests at
// or beyond 2100-01-01 00:00:00 return m_axis_tuser high and all tdata fields zero.
// There is no configuration and no state beyond the pipeline.
module unix_time_to_calendar import uttc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] unix_seconds
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [11:0] year, [15:12] month, [20:16] day_of_month, [23:21] weekday,
  // [28:24] hour_of_day, [34:29] minute_of_hour, [40:35] second_of_minute, [47:41] zero
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tuser    // [0] out_of_range
);

  // Pipeline valids, one per rank
  logic a_vld_q, b_vld_q, c_vld_q, d_vld_q, e_vld_q;
  logic a_rdy, b_rdy, c_rdy, d_rdy, e_rdy;

  // Payloads
  logic [31:0] a_sec_q;
  stg_b_t      b_d, b_q;
  stg_c_t      c_d, c_q;
  stg_d_t      d_d, d_q;
  res_t        e_d, e_q;

  // A rank loads when it is empty or its content moves on
  assign e_rdy = !e_vld_q || m_axis_tready;
  assign d_rdy = !d_vld_q || e_rdy;
  assign c_rdy = !c_vld_q || d_rdy;
  assign b_rdy = !b_vld_q || c_rdy;
  assign a_rdy = !a_vld_q || b_rdy;

  assign s_axis_tready = a_rdy;

  uttc_day_split u_day_split (
    .sec_i (a_sec_q),
    .stg_o (b_d)
  );

  uttc_group_split u_group_split (
    .stg_i (b_q),
    .stg_o (c_d)
  );

  uttc_year_split u_year_split (
    .stg_i (c_q),
    .stg_o (d_d)
  );

  uttc_month_time u_month_time (
    .stg_i (d_q),
    .res_o (e_d)
  );

  // Valid bits: advance a request wherever the next rank can take it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
    end else begin
      if (a_rdy) a_vld_q <= s_axis_tvalid;
      if (b_rdy) b_vld_q <= a_vld_q;
      if (c_rdy) c_vld_q <= b_vld_q;
      if (d_rdy) d_vld_q <= c_vld_q;
      if (e_rdy) e_vld_q <= d_vld_q;
    end
  end

  // Payload registers: load only with a valid request, hold otherwise
  always_ff @(posedge clk_i) begin
    if (a_rdy && s_axis_tvalid) a_sec_q <= s_axis_tdata;
    if (b_rdy && a_vld_q)       b_q     <= b_d;
    if (c_rdy && b_vld_q)       c_q     <= c_d;
    if (d_rdy && c_vld_q)       d_q     <= d_d;
    if (e_rdy && d_vld_q)       e_q     <= e_d;
  end

  assign m_axis_tvalid = e_vld_q;
  assign m_axis_tuser  = e_q.oor;
  assign m_axis_tdata  = {7'd0, e_q.second, e_q.minute, e_q.hour, e_q.weekday,
                          e_q.day, e_q.month, e_q.year};

endmodule
